// ----- src/acda_pkg.sv -----
package acda_pkg;

  localparam int MAX_NODES = 2048;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int ALPHABET  = 10;
  localparam int DIG_W     = 4;
  localparam int IDX_W     = $clog2(ALPHABET);
  localparam int CNT_W     = 12;
  localparam int WT_W      = 48;
  localparam int WEIGHT_BITS = 32;

  typedef enum logic [1:0] {
    F_INSERT = 2'd0,
    F_BUILD  = 2'd1,
    F_STEP   = 2'd2,
    F_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_AFTER_BLD  = 2'd2,
    ST_NOT_BUILT  = 2'd3
  } status_t;

  typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

  typedef struct packed {
    logic [CNT_W-1:0]       cnt;
    logic signed [WT_W-1:0] wt;
  } node_data_t;

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic logic signed [WT_W-1:0] sat_wt(input logic signed [WT_W-1:0] a,
                                                    input logic signed [WT_W-1:0] b);
    logic signed [WT_W:0] s;
    s = {a[WT_W-1], a} + {b[WT_W-1], b};
    if (s[WT_W] != s[WT_W-1]) begin
      return s[WT_W] ? {1'b1, {(WT_W-1){1'b0}}} : {1'b0, {(WT_W-1){1'b1}}};
    end
    return s[WT_W-1:0];
  endfunction

endpackage

// ----- src/aho_corasick_digit_automaton_core.sv -----
// Aho-Corasick automaton over decimal digits. Before build, insert items add one pattern
// digit each (pattern_end marks the last, where the count is bumped and the weight added);
// a build item runs the breadth-first failure-link pass; step items walk the built
// automaton and return the reached node with its count and summed weight. After reset the
// block clears its goto, failure and node tables and holds in_stall high meanwhile. Insert
// and step items read the goto row, then the node data, then load the result register. A
// no-op or step-before-build item, or an insert or build after build, skips the row read.
// Build walks the root row, then per trie node does a queue read, reads of its row, data
// and fail link, reads of the fail target's row and data, one write-back and a pass over
// the ten child slots on the fail and queue write ports. A result waits in the output
// register while the next item is already accepted.
module aho_corasick_digit_automaton_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_func,
  input  logic [acda_pkg::DIG_W-1:0] in_digit,
  input  logic                       in_pattern_end,
  input  logic signed [31:0]         in_pattern_weight,
  input  logic [10:0]                in_current_state,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [acda_pkg::NODE_W-1:0] out_next_state,
  output logic [acda_pkg::CNT_W-1:0]  out_match_count,
  output logic signed [acda_pkg::WT_W-1:0] out_match_weight,
  output logic [1:0]                 out_status
);
  import acda_pkg::*;

  typedef enum logic [9:0] {
    S_CLR   = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_ROW   = 10'b00_0000_0100,
    S_NODE  = 10'b00_0000_1000,
    S_RPUSH = 10'b00_0001_0000,
    S_POP   = 10'b00_0010_0000,
    S_U     = 10'b00_0100_0000,
    S_F     = 10'b00_1000_0000,
    S_M     = 10'b01_0000_0000,
    S_CH    = 10'b10_0000_0000
  } state_t;

  // Memories: goto rows, failure links, node count/weight, breadth-first queue
  row_t                goto_mem [MAX_NODES];
  logic [NODE_W-1:0]   fail_mem [MAX_NODES];
  node_data_t          node_mem [MAX_NODES];
  logic [NODE_W-1:0]   queue_mem [MAX_NODES];

  row_t                goto_rd_r;
  logic [NODE_W-1:0]   fail_rd_r;
  node_data_t          node_rd_r;
  logic [NODE_W-1:0]   queue_rd_r;

  logic goto_re, goto_we, fail_re, fail_we, node_re, node_we, queue_re, queue_we;
  logic [NODE_W-1:0] goto_ra, goto_wa, fail_ra, fail_wa, node_ra, node_wa;
  logic [NODE_W-1:0] queue_ra, queue_wa, queue_wd, fail_wd;
  row_t              goto_wd;
  node_data_t        node_wd;

  always_ff @(posedge clk) begin
    if (goto_we) goto_mem[goto_wa] <= goto_wd;
    if (goto_re) goto_rd_r <= goto_mem[goto_ra];
  end

  always_ff @(posedge clk) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    if (fail_re) fail_rd_r <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    if (node_re) node_rd_r <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    if (queue_re) queue_rd_r <= queue_mem[queue_ra];
  end

  // Control and item registers
  state_t              state_r, state_nxt;
  logic [NODE_W-1:0]   clr_r, clr_nxt;
  logic                built_r, built_nxt;
  logic [NODE_W-1:0]   used_r, used_nxt;
  logic [NODE_W-1:0]   cursor_r, cursor_nxt;
  logic [NODE_W-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [NODE_W-1:0]   u_r, u_nxt;
  row_t                rowu_r, rowu_nxt;
  node_data_t          ndu_r, ndu_nxt;
  func_t               func_r, func_nxt;
  logic [DIG_W-1:0]    dig_r, dig_nxt;
  logic                end_r, end_nxt;
  logic signed [WT_W-1:0] wt_r, wt_nxt;
  logic [NODE_W-1:0]   tgt_r, tgt_nxt;
  status_t             stat_r, stat_nxt;
  logic                upd_r, upd_nxt;
  logic                zero_r, zero_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]   out_ns_r, out_ns_nxt;
  node_data_t          out_nd_r, out_nd_nxt;
  status_t             out_st_r, out_st_nxt;

  logic [DIG_W-1:0]    dig_c;
  logic [NODE_W-1:0]   sel_c, child_c, new_c;
  node_data_t          nd_c;
  row_t                merge_c;

  always_comb begin
    dig_c = (in_digit >= DIG_W'(ALPHABET)) ? DIG_W'(ALPHABET - 1) : in_digit;
    sel_c = goto_rd_r[dig_r[IDX_W-1:0]];
    child_c = rowu_r[idx_r];
    new_c = used_r + NODE_W'(1);
    for (int c = 0; c < ALPHABET; c++) begin
      merge_c[c] = (rowu_r[c] == '0) ? goto_rd_r[c] : rowu_r[c];
    end
    if (zero_r) begin
      nd_c = '0;
    end else if (upd_r) begin
      nd_c.cnt = sat_cnt(node_rd_r.cnt, CNT_W'(1));
      nd_c.wt  = sat_wt(node_rd_r.wt, wt_r);
    end else begin
      nd_c = node_rd_r;
    end
  end

  always_comb begin
    state_nxt = state_r;   clr_nxt = clr_r;     built_nxt = built_r;
    used_nxt = used_r;     cursor_nxt = cursor_r;
    head_nxt = head_r;     tail_nxt = tail_r;   idx_nxt = idx_r;
    u_nxt = u_r;           rowu_nxt = rowu_r;   ndu_nxt = ndu_r;
    func_nxt = func_r;     dig_nxt = dig_r;     end_nxt = end_r;   wt_nxt = wt_r;
    tgt_nxt = tgt_r;       stat_nxt = stat_r;   upd_nxt = upd_r;   zero_nxt = zero_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_ns_nxt = out_ns_r; out_nd_nxt = out_nd_r; out_st_nxt = out_st_r;
    goto_re = 1'b0; goto_we = 1'b0; goto_ra = '0; goto_wa = '0; goto_wd = '0;
    fail_re = 1'b0; fail_we = 1'b0; fail_ra = '0; fail_wa = '0; fail_wd = '0;
    node_re = 1'b0; node_we = 1'b0; node_ra = '0; node_wa = '0; node_wd = '0;
    queue_re = 1'b0; queue_we = 1'b0; queue_ra = '0; queue_wa = '0; queue_wd = '0;
    in_stall = (state_r != S_IDLE);

    case (state_r)
      S_CLR: begin
        goto_we = 1'b1; goto_wa = clr_r;
        fail_we = 1'b1; fail_wa = clr_r;
        node_we = 1'b1; node_wa = clr_r;
        clr_nxt = clr_r + NODE_W'(1);
        if (clr_r == NODE_W'(MAX_NODES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = func_t'(in_func);
          dig_nxt  = dig_c;
          end_nxt  = in_pattern_end;
          // sign-extend the low weight bits to the accumulator width
          wt_nxt   = WT_W'(signed'(in_pattern_weight[WEIGHT_BITS-1:0]));
          zero_nxt = 1'b0;
          upd_nxt  = 1'b0;
          stat_nxt = ST_OK;
          case (func_t'(in_func))
            F_INSERT: begin
              if (built_r) begin
                tgt_nxt = cursor_r; stat_nxt = ST_AFTER_BLD;
                node_re = 1'b1; node_ra = cursor_r;
                state_nxt = S_NODE;
              end else begin
                goto_re = 1'b1; goto_ra = cursor_r;
                state_nxt = S_ROW;
              end
            end
            F_BUILD: begin
              if (built_r) begin
                tgt_nxt = '0; stat_nxt = ST_AFTER_BLD;
                node_re = 1'b1; node_ra = '0;
                state_nxt = S_NODE;
              end else begin
                goto_re = 1'b1; goto_ra = '0;
                idx_nxt = '0; head_nxt = '0; tail_nxt = '0;
                state_nxt = S_RPUSH;
              end
            end
            F_STEP: begin
              if (!built_r) begin
                zero_nxt = 1'b1; tgt_nxt = '0; stat_nxt = ST_NOT_BUILT;
                state_nxt = S_NODE;
              end else begin
                goto_re = 1'b1;
                goto_ra = ({1'b0, in_current_state} >= 12'(MAX_NODES)) ? '0
                          : in_current_state[NODE_W-1:0];
                state_nxt = S_ROW;
              end
            end
            default: begin
              zero_nxt = 1'b1; tgt_nxt = '0;
              state_nxt = S_NODE;
            end
          endcase
        end
      end
      S_ROW: begin
        if (func_r == F_STEP) begin
          tgt_nxt = sel_c;
        end else if (sel_c != '0) begin
          tgt_nxt = sel_c; upd_nxt = end_r;
          cursor_nxt = end_r ? '0 : sel_c;
        end else if (used_r >= NODE_W'(MAX_NODES - 1)) begin
          // trie full: report the cursor node, drop the weight
          tgt_nxt = cursor_r; stat_nxt = ST_FULL;
          cursor_nxt = end_r ? '0 : cursor_r;
        end else begin
          used_nxt = new_c;
          goto_we = 1'b1; goto_wa = cursor_r;
          goto_wd = goto_rd_r;
          goto_wd[dig_r[IDX_W-1:0]] = new_c;
          tgt_nxt = new_c; upd_nxt = end_r;
          cursor_nxt = end_r ? '0 : new_c;
        end
        node_re = 1'b1;
        node_ra = (func_r == F_STEP || sel_c != '0) ? sel_c
                  : ((used_r >= NODE_W'(MAX_NODES - 1)) ? cursor_r : new_c);
        state_nxt = S_NODE;
      end
      S_NODE: begin
        // hold here while the previous result still waits
        if (!out_valid_r || !out_stall) begin
          if (upd_r) begin
            node_we = 1'b1; node_wa = tgt_r; node_wd = nd_c;
          end
          out_valid_nxt = 1'b1;
          out_ns_nxt = zero_r ? '0 : tgt_r;
          out_nd_nxt = nd_c;
          out_st_nxt = stat_r;
          state_nxt = S_IDLE;
        end
      end
      S_RPUSH: begin
        if (goto_rd_r[idx_r] != '0) begin
          queue_we = 1'b1; queue_wa = tail_r; queue_wd = goto_rd_r[idx_r];
          tail_nxt = tail_r + NODE_W'(1);
        end
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(ALPHABET - 1)) state_nxt = S_POP;
      end
      S_POP: begin
        if (head_r == tail_r) begin
          built_nxt = 1'b1; cursor_nxt = '0;
          tgt_nxt = '0; stat_nxt = ST_OK; upd_nxt = 1'b0;
          node_re = 1'b1; node_ra = '0;
          state_nxt = S_NODE;
        end else begin
          queue_re = 1'b1; queue_ra = head_r;
          head_nxt = head_r + NODE_W'(1);
          state_nxt = S_U;
        end
      end
      S_U: begin
        u_nxt = queue_rd_r;
        goto_re = 1'b1; goto_ra = queue_rd_r;
        node_re = 1'b1; node_ra = queue_rd_r;
        fail_re = 1'b1; fail_ra = queue_rd_r;
        state_nxt = S_F;
      end
      S_F: begin
        rowu_nxt = goto_rd_r;
        ndu_nxt  = node_rd_r;
        goto_re = 1'b1; goto_ra = fail_rd_r;
        node_re = 1'b1; node_ra = fail_rd_r;
        state_nxt = S_M;
      end
      S_M: begin
        // fold the failure target into the node and fill missing transitions
        node_we = 1'b1; node_wa = u_r;
        node_wd.cnt = sat_cnt(ndu_r.cnt, node_rd_r.cnt);
        node_wd.wt  = sat_wt(ndu_r.wt, node_rd_r.wt);
        goto_we = 1'b1; goto_wa = u_r; goto_wd = merge_c;
        idx_nxt = '0;
        state_nxt = S_CH;
      end
      S_CH: begin
        if (child_c != '0) begin
          fail_we = 1'b1; fail_wa = child_c; fail_wd = goto_rd_r[idx_r];
          queue_we = 1'b1; queue_wa = tail_r; queue_wd = child_c;
          tail_nxt = tail_r + NODE_W'(1);
        end
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(ALPHABET - 1)) state_nxt = S_POP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      built_r <= 1'b0;
      used_r <= '0;
      cursor_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      built_r <= built_nxt;
      used_r <= used_nxt;
      cursor_r <= cursor_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt;
    rowu_r <= rowu_nxt;
    ndu_r <= ndu_nxt;
    func_r <= func_nxt;
    dig_r <= dig_nxt;
    end_r <= end_nxt;
    wt_r <= wt_nxt;
    tgt_r <= tgt_nxt;
    stat_r <= stat_nxt;
    upd_r <= upd_nxt;
    zero_r <= zero_nxt;
    out_ns_r <= out_ns_nxt;
    out_nd_r <= out_nd_nxt;
    out_st_r <= out_st_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_next_state   = out_ns_r;
  assign out_match_count  = out_nd_r.cnt;
  assign out_match_weight = out_nd_r.wt;
  assign out_status       = out_st_r;

endmodule

// ----- src/acda_checker.sv -----
module acda_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [10:0] out_next_state,
  input logic [11:0] out_match_count,
  input logic [47:0] out_match_weight,
  input logic [1:0]  out_status
);
  import acda_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken before the first completed");

  a_unbuilt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOT_BUILT |->
      out_next_state == '0 && out_match_count == '0 && out_match_weight == '0)
    else $error("step before build returned data");

  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_stall)
    else $error("item accepted during clearing");

endmodule

bind aho_corasick_digit_automaton_core acda_port_props u_acda_port_props (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_next_state(out_next_state),
  .out_match_count(out_match_count), .out_match_weight(out_match_weight),
  .out_status(out_status)
);
